### src/cmqm_pkg.sv
// ============================================================================
// CAN mailbox queue manager package
// Shared constants, codes, request and result types, and the error-to-status
// conversion for the CAN mailbox queue manager.
// ============================================================================
package cmqm_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TX_MAILBOXES = 2;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MBX_W  = $clog2(TX_MAILBOXES + 1);

    localparam logic [2:0] CMD_TX_REQ   = 3'd0;
    localparam logic [2:0] CMD_TX_DONE  = 3'd1;
    localparam logic [2:0] CMD_RX_FRAME = 3'd2;
    localparam logic [2:0] CMD_CTRL_ERR = 3'd3;
    localparam logic [2:0] CMD_RX_REQ   = 3'd4;
    localparam logic [2:0] CMD_STATUS   = 3'd5;

    localparam logic [1:0] ACT_STATUS  = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_DELIVER = 2'd2;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_RX       = 4'd1;
    localparam logic [3:0] ST_TX_FULL     = 4'd2;
    localparam logic [3:0] ST_LEC_BASE    = 4'd2;
    localparam logic [3:0] ST_BAD_MAILBOX = 4'd10;
    localparam logic [3:0] ST_RX_FULL     = 4'd11;
    localparam logic [3:0] ST_UNKNOWN     = 4'd12;

    localparam logic [31:0] ERR_BAD_MAILBOX = 32'h0000_0400;
    localparam logic [31:0] ERR_RX_FULL     = 32'h0000_0800;

    localparam logic [4:0] PENDING_MAX = 5'd31;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [4:0]  mailbox_num;
        logic [31:0] error_word;
    } req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  used_mailbox;
        logic [31:0] out_id;
        logic [3:0]  out_len;
        logic [63:0] out_data;
        logic [3:0]  status;
        logic [4:0]  tx_pending;
        logic [4:0]  rx_pending;
    } res_t;

    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } frame_t;

    function automatic logic [3:0] err_status(input logic [31:0] w);
        logic [3:0] s;
        if (w == 32'd0) begin
            s = ST_OK;
        end else if (w[2:0] != 3'd0) begin
            s = ST_LEC_BASE + {1'b0, w[2:0]};
        end else if (w == ERR_BAD_MAILBOX) begin
            s = ST_BAD_MAILBOX;
        end else if (w == ERR_RX_FULL) begin
            s = ST_RX_FULL;
        end else begin
            s = ST_UNKNOWN;
        end
        return s;
    endfunction

    function automatic logic [4:0] sat_pending(input logic [FILL_W-1:0] f);
        logic [4:0] p;
        if (32'(f) > 32'(PENDING_MAX)) begin
            p = PENDING_MAX;
        end else begin
            p = 5'(f);
        end
        return p;
    endfunction

endpackage

### src/can_mailbox_queue_manager.sv
// ============================================================================
// CAN mailbox queue manager
// Transmit mailbox allocation, transmit and receive frame queues held in
// synchronous memories, and latched controller error reporting.
// ============================================================================
// On acceptance of a request the head entry of both queue memories is read
// into registers; in the decision state S_EXEC the block then decides the
// result, updates the queue pointers and mailbox flags, writes a pushed frame
// back to its memory and loads the result register. A new request is taken as
// soon as the result register has been loaded, even while the result still
// waits to be taken; a full result register holds the request in its decision
// state until it is freed.
module can_mailbox_queue_manager
    import cmqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    req_t   req_reg;
    frame_t tx_mem [QUEUE_DEPTH];
    frame_t rx_mem [QUEUE_DEPTH];
    frame_t tx_rd_reg;
    frame_t rx_rd_reg;

    logic [QPTR_W-1:0]     tx_head_reg, tx_head_next;
    logic [QPTR_W-1:0]     rx_head_reg, rx_head_next;
    logic [FILL_W-1:0]     tx_fill_reg, tx_fill_next;
    logic [FILL_W-1:0]     rx_fill_reg, rx_fill_next;
    logic [TX_MAILBOXES:0] busy_reg, busy_next;
    logic                  err_latched_reg, err_latched_next;
    logic [31:0]           err_word_reg, err_word_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    logic              req_acc;
    logic              finish;
    logic              tx_we, rx_we;
    logic [QPTR_W-1:0] tx_wa, rx_wa;
    frame_t            req_frame;

    function automatic logic [QPTR_W-1:0] wrap_add(input logic [QPTR_W-1:0] head,
                                                   input logic [FILL_W-1:0] fill);
        logic [QPTR_W:0] sum;
        sum = (QPTR_W+1)'(head) + (QPTR_W+1)'(fill);
        if (sum >= (QPTR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QPTR_W+1)'(QUEUE_DEPTH);
        end
        return QPTR_W'(sum);
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign finish    = (state_reg == S_EXEC) && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign req_frame.id   = req_reg.frame_id;
    assign req_frame.len  = req_reg.frame_len;
    assign req_frame.data = req_reg.frame_data;

    assign tx_wa = wrap_add(tx_head_reg, tx_fill_reg);
    assign rx_wa = wrap_add(rx_head_reg, rx_fill_reg);

    always_comb
    begin
        logic              found;
        logic [4:0]        pick;
        logic [MBX_W-1:0]  mb_idx;
        logic [3:0]        cur_status;

        state_next       = state_reg;
        tx_head_next     = tx_head_reg;
        rx_head_next     = rx_head_reg;
        tx_fill_next     = tx_fill_reg;
        rx_fill_next     = rx_fill_reg;
        busy_next        = busy_reg;
        err_latched_next = err_latched_reg;
        err_word_next    = err_word_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_next         = res_reg;
        tx_we            = 1'b0;
        rx_we            = 1'b0;
        found            = 1'b0;
        pick             = 5'd0;
        mb_idx           = MBX_W'(req_reg.mailbox_num);
        cur_status       = err_status(err_word_reg);

        for (int i = TX_MAILBOXES; i >= 1; i--) begin
            if (!busy_reg[MBX_W'(i)]) begin
                found = 1'b1;
                pick  = 5'(i);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish) begin
                    state_next = S_IDLE;
                    res_next   = '0;
                    case (req_reg.cmd)
                        CMD_TX_REQ:
                        begin
                            if (err_latched_reg && err_word_reg != ERR_RX_FULL) begin
                                err_latched_next = 1'b0;
                                res_next.status  = cur_status;
                            end else if (found) begin
                                busy_next[MBX_W'(pick)] = 1'b1;
                                res_next.action       = ACT_START;
                                res_next.used_mailbox = pick;
                                res_next.out_id       = req_frame.id;
                                res_next.out_len      = req_frame.len;
                                res_next.out_data     = req_frame.data;
                            end else if (tx_fill_reg < FILL_W'(QUEUE_DEPTH)) begin
                                tx_we        = 1'b1;
                                tx_fill_next = tx_fill_reg + FILL_W'(1);
                            end else begin
                                res_next.status = ST_TX_FULL;
                            end
                        end
                        CMD_TX_DONE:
                        begin
                            if (req_reg.mailbox_num <= 5'(TX_MAILBOXES)) begin
                                busy_next[mb_idx] = 1'b0;
                                if (tx_fill_reg != '0) begin
                                    busy_next[mb_idx]     = 1'b1;
                                    res_next.action       = ACT_START;
                                    res_next.used_mailbox = req_reg.mailbox_num;
                                    res_next.out_id       = tx_rd_reg.id;
                                    res_next.out_len      = tx_rd_reg.len;
                                    res_next.out_data     = tx_rd_reg.data;
                                    tx_head_next = wrap_add(tx_head_reg, FILL_W'(1));
                                    tx_fill_next = tx_fill_reg - FILL_W'(1);
                                end
                            end else begin
                                err_latched_next = 1'b1;
                                err_word_next    = ERR_BAD_MAILBOX;
                            end
                        end
                        CMD_RX_FRAME:
                        begin
                            if (rx_fill_reg < FILL_W'(QUEUE_DEPTH)) begin
                                rx_we        = 1'b1;
                                rx_fill_next = rx_fill_reg + FILL_W'(1);
                            end else begin
                                err_latched_next = 1'b1;
                                err_word_next    = ERR_RX_FULL;
                            end
                        end
                        CMD_CTRL_ERR:
                        begin
                            err_latched_next = 1'b1;
                            err_word_next    = req_reg.error_word;
                        end
                        CMD_RX_REQ:
                        begin
                            if (err_latched_reg) begin
                                err_latched_next = 1'b0;
                                res_next.status  = cur_status;
                            end else if (rx_fill_reg != '0) begin
                                res_next.action   = ACT_DELIVER;
                                res_next.out_id   = rx_rd_reg.id;
                                res_next.out_len  = rx_rd_reg.len;
                                res_next.out_data = rx_rd_reg.data;
                                rx_head_next = wrap_add(rx_head_reg, FILL_W'(1));
                                rx_fill_next = rx_fill_reg - FILL_W'(1);
                            end else begin
                                res_next.status = ST_NO_RX;
                            end
                        end
                        CMD_STATUS:
                        begin
                            res_next.status = cur_status;
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.tx_pending = sat_pending(tx_fill_next);
                    res_next.rx_pending = sat_pending(rx_fill_next);
                    res_valid_next      = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            tx_head_reg     <= '0;
            rx_head_reg     <= '0;
            tx_fill_reg     <= '0;
            rx_fill_reg     <= '0;
            busy_reg        <= '0;
            err_latched_reg <= 1'b0;
            err_word_reg    <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tx_head_reg     <= tx_head_next;
            rx_head_reg     <= rx_head_next;
            tx_fill_reg     <= tx_fill_next;
            rx_fill_reg     <= rx_fill_next;
            busy_reg        <= busy_next;
            err_latched_reg <= err_latched_next;
            err_word_reg    <= err_word_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (req_acc) begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_we) begin
            tx_mem[tx_wa] <= req_frame;
        end
        if (req_acc) begin
            tx_rd_reg <= tx_mem[tx_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we) begin
            rx_mem[rx_wa] <= req_frame;
        end
        if (req_acc) begin
            rx_rd_reg <= rx_mem[rx_head_reg];
        end
    end

    a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("Transmit queue fill exceeds its depth.");

    a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("Receive queue fill exceeds its depth.");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> (state_reg == S_EXEC))
        else $error("An accepted request did not enter its decision cycle.");

    a_start_mailbox: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.action == ACT_START)
            |-> (res_reg.used_mailbox <= 5'(TX_MAILBOXES)))
        else $error("A transmission started on a mailbox that does not exist.");

endmodule
